@@ hdl/spherical_angles_to_quaternion_unit_assert.svh @@
// Assertion macros shared by the shortest-arc quaternion unit.
`ifndef SPHERICAL_ANGLES_TO_QUATERNION_UNIT_ASSERT_SVH
`define SPHERICAL_ANGLES_TO_QUATERNION_UNIT_ASSERT_SVH

// Checked on every rising edge outside reset.
`define SAQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define SAQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ hdl/saq_pkg.sv @@
`default_nettype none

package saq_pkg;

    localparam int ANGLE_BITS = 16;
    localparam int FRAC_BITS  = 15;

    // Quotient bits kept by each divider: one above the fraction for saturation.
    localparam int QBITS = FRAC_BITS + 1;
    // Numerator: magnitude up to 2^31 shifted by QBITS, plus the root.
    localparam int NUM_W = 33 + QBITS;
    // Denominator: twice the root, the root being at most 2^31.
    localparam int DEN_W = 33;

    localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    // dz at or below minus this magnitude counts as pointing away from +z.
    localparam logic [30:0] OPP_LIMIT   = 31'h4000_0000 - 31'd1073;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

    localparam int HORNER_STEPS = 4;
    localparam logic [6:0] HORNER_DIV [HORNER_STEPS] = '{7'd72, 7'd42, 7'd20, 7'd6};
    // floor(2^32 / d); one correction step after the product gives the exact quotient.
    localparam logic [29:0] HORNER_RECIP [HORNER_STEPS] = '{
        30'((64'd1 << 32) / 64'd72),
        30'((64'd1 << 32) / 64'd42),
        30'((64'd1 << 32) / 64'd20),
        30'((64'd1 << 32) / 64'd6)
    };

    typedef struct packed {
        logic        neg;
        logic [30:0] mag;
    } t_sgn_mag;

    typedef struct packed {
        logic neg;
        logic opposite;
    } t_div_side;

endpackage

`default_nettype wire

@@ hdl/saq_sine.sv @@
`default_nettype none

module saq_sine (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    input  wire [31:0]            i_turn,
    output logic                  o_valid,
    output saq_pkg::t_sgn_mag     o_sine
);
    import saq_pkg::*;

    localparam int CARRY_LEN = 3 * HORNER_STEPS;
    localparam int Z2_LEN    = 3 * (HORNER_STEPS - 1) + 1;

    logic [30:0] r_r;
    logic [1:0]  r_quad0;
    logic        r_v0;
    logic [30:0] r_z;
    logic [1:0]  r_quad1;
    logic        r_v1;

    logic [30:0] r_zc    [0:CARRY_LEN];
    logic [1:0]  r_quadc [0:CARRY_LEN];
    logic        r_vc    [0:CARRY_LEN];
    logic [31:0] r_z2c   [0:Z2_LEN-1];

    logic [31:0] r_p    [0:HORNER_STEPS-1];
    logic [31:0] r_pd   [0:HORNER_STEPS-1];
    logic [61:0] r_prod [0:HORNER_STEPS-1];
    logic [30:0] r_t    [1:HORNER_STEPS];
    logic [30:0] w_tin  [0:HORNER_STEPS-1];

    logic [30:0] r_s;
    logic [1:0]  r_quadf;
    logic        r_vf;
    t_sgn_mag    r_sine;
    logic        r_vo;

    logic [30:0] n_r;
    logic [61:0] w_zp;
    logic [61:0] w_z2p;
    logic [61:0] w_sp;
    logic [30:0] w_mag;

    // Fold into the first quadrant.
    always_comb begin
        n_r = {1'b0, i_turn[29:0]};
        if (i_turn[30]) begin
            n_r = ONE_Q30 - n_r;
        end
    end

    assign w_zp  = 62'(r_r) * 62'(HALF_PI_Q30);
    assign w_z2p = 62'(r_z) * 62'(r_z);

    always_ff @(posedge i_clk) begin
        r_r        <= n_r;
        r_quad0    <= i_turn[31:30];
        r_z        <= w_zp[60:30];
        r_quad1    <= r_quad0;
        r_zc[0]    <= r_z;
        r_z2c[0]   <= w_z2p[61:30];
        r_quadc[0] <= r_quad1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0     <= 1'b0;
            r_v1     <= 1'b0;
            r_vc[0]  <= 1'b0;
        end else begin
            r_v0     <= i_valid;
            r_v1     <= r_v0;
            r_vc[0]  <= r_v1;
        end
    end

    genvar j;
    generate
        for (j = 0; j < CARRY_LEN; j++) begin : g_carry
            always_ff @(posedge i_clk) begin
                r_zc[j+1]    <= r_zc[j];
                r_quadc[j+1] <= r_quadc[j];
            end
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vc[j+1] <= 1'b0;
                end else begin
                    r_vc[j+1] <= r_vc[j];
                end
            end
        end
        for (j = 0; j < Z2_LEN - 1; j++) begin : g_z2_carry
            always_ff @(posedge i_clk) begin
                r_z2c[j+1] <= r_z2c[j];
            end
        end
    endgenerate

    // Horner steps: t = 1 - (z2 * t) / d, three stages each.
    genvar k;
    generate
        for (k = 0; k < HORNER_STEPS; k++) begin : g_horner
            logic [62:0] w_pp;
            logic [29:0] w_q0;
            logic [36:0] w_qd;
            logic [31:0] w_rem;
            logic [30:0] w_q;

            if (k == 0) begin : g_first
                assign w_tin[k] = ONE_Q30;
            end else begin : g_next
                assign w_tin[k] = r_t[k];
            end

            assign w_pp  = 63'(r_z2c[3*k]) * 63'(w_tin[k]);
            assign w_q0  = r_prod[k][61:32];
            assign w_qd  = 37'(w_q0) * 37'(HORNER_DIV[k]);
            assign w_rem = r_pd[k] - w_qd[31:0];
            assign w_q   = 31'(w_q0) + 31'(w_rem >= 32'(HORNER_DIV[k]));

            always_ff @(posedge i_clk) begin
                r_p[k]    <= w_pp[61:30];
                r_prod[k] <= 62'(r_p[k]) * 62'(HORNER_RECIP[k]);
                r_pd[k]   <= r_p[k];
                r_t[k+1]  <= ONE_Q30 - w_q;
            end
        end
    endgenerate

    assign w_sp  = 62'(r_zc[CARRY_LEN]) * 62'(r_t[HORNER_STEPS]);
    assign w_mag = (r_s > ONE_Q30) ? ONE_Q30 : r_s;

    always_ff @(posedge i_clk) begin
        r_s        <= w_sp[60:30];
        r_quadf    <= r_quadc[CARRY_LEN];
        // A zero result carries no sign, so later sign logic sees a true zero.
        r_sine.neg <= r_quadf[1] && (w_mag != 31'd0);
        r_sine.mag <= w_mag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vf <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            r_vf <= r_vc[CARRY_LEN];
            r_vo <= r_vf;
        end
    end

    assign o_valid = r_vo;
    assign o_sine  = r_sine;

endmodule

`default_nettype wire

@@ hdl/saq_div.sv @@
`default_nettype none

module saq_div (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    input  wire [saq_pkg::NUM_W-1:0]     i_num,
    input  wire [saq_pkg::DEN_W-1:0]     i_den,
    input  wire saq_pkg::t_div_side      i_side,
    output logic                         o_valid,
    output logic signed [saq_pkg::QBITS-1:0] o_quot,
    output saq_pkg::t_div_side           o_side
);
    import saq_pkg::*;

    logic [DEN_W-1:0] r_rem  [0:QBITS-1];
    logic [QBITS-1:0] r_nlo  [0:QBITS-1];
    logic [QBITS-1:0] r_q    [0:QBITS];
    logic [DEN_W-1:0] r_den  [0:QBITS-1];
    logic             r_ovf  [0:QBITS];
    t_div_side        r_side [0:QBITS];
    logic             r_v    [0:QBITS];

    logic signed [QBITS-1:0] r_quot;
    t_div_side               r_side_o;
    logic                    r_vo;
    logic                    w_big;
    logic [QBITS-1:0]        w_q;

    // The quotient fits QBITS bits unless the numerator reaches den << QBITS.
    always_ff @(posedge i_clk) begin
        r_ovf[0]  <= i_num >= {i_den, {QBITS{1'b0}}};
        r_rem[0]  <= i_num[NUM_W-1:QBITS];
        r_nlo[0]  <= i_num[QBITS-1:0];
        r_den[0]  <= i_den;
        r_q[0]    <= '0;
        r_side[0] <= i_side;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
    end

    genvar j;
    generate
        for (j = 0; j < QBITS; j++) begin : g_step
            logic [DEN_W:0] w_rs;
            logic [DEN_W:0] w_diff;
            logic           w_ge;

            assign w_rs   = {r_rem[j], r_nlo[j][QBITS-1-j]};
            assign w_diff = w_rs - {1'b0, r_den[j]};
            assign w_ge   = w_rs >= {1'b0, r_den[j]};

            always_ff @(posedge i_clk) begin
                r_q[j+1]    <= {r_q[j][QBITS-2:0], w_ge};
                r_ovf[j+1]  <= r_ovf[j];
                r_side[j+1] <= r_side[j];
            end

            if (j < QBITS - 1) begin : g_carry
                always_ff @(posedge i_clk) begin
                    r_rem[j+1] <= w_ge ? w_diff[DEN_W-1:0] : w_rs[DEN_W-1:0];
                    r_nlo[j+1] <= r_nlo[j];
                    r_den[j+1] <= r_den[j];
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[j+1] <= 1'b0;
                end else begin
                    r_v[j+1] <= r_v[j];
                end
            end
        end
    endgenerate

    assign w_q = r_q[QBITS];

    // Saturate to [-2^F, 2^F-1] and apply the sign.
    always_comb begin
        if (r_side[QBITS].neg) begin
            w_big = r_ovf[QBITS] || (w_q > (QBITS'(1) << FRAC_BITS));
        end else begin
            w_big = r_ovf[QBITS] || w_q[QBITS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_side_o <= r_side[QBITS];
        if (r_side[QBITS].neg) begin
            r_quot <= w_big ? {1'b1, {FRAC_BITS{1'b0}}} : $signed(QBITS'(0) - w_q);
        end else begin
            r_quot <= w_big ? {1'b0, {FRAC_BITS{1'b1}}} : $signed(w_q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else begin
            r_vo <= r_v[QBITS];
        end
    end

    assign o_valid = r_vo;
    assign o_quot  = r_quot;
    assign o_side  = r_side_o;

endmodule

`default_nettype wire

@@ hdl/spherical_angles_to_quaternion_unit.sv @@
// Throughput: one request per cycle; busy stays low and requests are never held off.
// The pipeline depth: 17 sine stages, one direction product stage,
// 33 square-root stages (a load stage and 32 steps), 18 divider stages and the result register.
// Reset (synchronous, active low) clears all valid bits; no strobe follows reset.
`default_nettype none

module spherical_angles_to_quaternion_unit (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_start,
    output logic                                  o_busy,
    input  wire [saq_pkg::ANGLE_BITS-1:0]         i_phi_angle,
    input  wire [saq_pkg::ANGLE_BITS-1:0]         i_theta_angle,
    output logic                                  o_strobe,
    output logic [saq_pkg::FRAC_BITS-1:0]         o_quat_w,
    output logic signed [saq_pkg::FRAC_BITS:0]    o_quat_x,
    output logic signed [saq_pkg::FRAC_BITS:0]    o_quat_y,
    output logic                                  o_opposite_flag
);
    import saq_pkg::*;

`include "spherical_angles_to_quaternion_unit_assert.svh"

    localparam int SQRT_STEPS = 32;

    // ------------------------------------------------------------------
    // Request intake. The pipeline never stalls, so every request is taken.
    // Angles become 32-bit turns; cosine is the sine a quarter turn ahead.
    // ------------------------------------------------------------------
    logic        w_accept;
    logic [31:0] w_phi_turn;
    logic [31:0] w_theta_turn;

    assign o_busy       = 1'b0;
    assign w_accept     = i_start && !o_busy;
    assign w_phi_turn   = 32'(i_phi_angle) << (32 - ANGLE_BITS);
    assign w_theta_turn = 32'(i_theta_angle) << (32 - ANGLE_BITS);

    logic     w_v_sp, w_v_cp, w_v_st, w_v_ct;
    t_sgn_mag w_sp, w_cp, w_st, w_ct;

    saq_sine u_sin_phi (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_turn  (w_phi_turn),
        .o_valid (w_v_sp),
        .o_sine  (w_sp)
    );

    saq_sine u_cos_phi (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_turn  (w_phi_turn + QUARTER_TURN),
        .o_valid (w_v_cp),
        .o_sine  (w_cp)
    );

    saq_sine u_sin_theta (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_turn  (w_theta_turn),
        .o_valid (w_v_st),
        .o_sine  (w_st)
    );

    saq_sine u_cos_theta (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_turn  (w_theta_turn + QUARTER_TURN),
        .o_valid (w_v_ct),
        .o_sine  (w_ct)
    );

    // ------------------------------------------------------------------
    // Direction products: dx = sin(phi) sin(theta), dz = sin(phi) cos(theta).
    // Magnitudes are multiplied and truncated; the sign is the xor of signs.
    // ------------------------------------------------------------------
    logic [61:0] w_dxp;
    logic [61:0] w_dzp;
    logic [30:0] r_dxm, r_dzm;
    logic        r_dx_neg, r_dz_neg;
    t_sgn_mag    r_dy_p;
    logic        r_pv;

    assign w_dxp = 62'(w_sp.mag) * 62'(w_st.mag);
    assign w_dzp = 62'(w_sp.mag) * 62'(w_ct.mag);

    always_ff @(posedge i_clk) begin
        r_dxm    <= w_dxp[60:30];
        r_dzm    <= w_dzp[60:30];
        r_dx_neg <= w_sp.neg ^ w_st.neg;
        r_dz_neg <= w_sp.neg ^ w_ct.neg;
        r_dy_p   <= w_cp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= w_v_sp && w_v_cp && w_v_st && w_v_ct;
        end
    end

    // ------------------------------------------------------------------
    // h = 1 + dz in Q30, and the test for a direction almost opposite +z.
    // A zero product has no sign. The results seed the square-root pipe.
    // ------------------------------------------------------------------
    logic        w_dz_neg;
    logic        w_dx_neg;
    logic        n_flag;
    logic [31:0] n_h;

    assign w_dz_neg = r_dz_neg && (r_dzm != 31'd0);
    assign w_dx_neg = r_dx_neg && (r_dxm != 31'd0);
    assign n_flag   = w_dz_neg && (r_dzm >= OPP_LIMIT);
    assign n_h      = w_dz_neg ? 32'(ONE_Q30) - 32'(r_dzm) : 32'(ONE_Q30) + 32'(r_dzm);

    // ------------------------------------------------------------------
    // Square root s = floor(sqrt(h * 2^31)), two radicand bits per stage.
    // Each stage compares the running remainder against 4*root + 1.
    // ------------------------------------------------------------------
    logic [32:0] r_rem   [0:SQRT_STEPS];
    logic [31:0] r_root  [0:SQRT_STEPS];
    logic [31:0] r_sh    [0:SQRT_STEPS];
    logic        r_sflag [0:SQRT_STEPS];
    t_sgn_mag    r_sdx   [0:SQRT_STEPS];
    t_sgn_mag    r_sdy   [0:SQRT_STEPS];
    logic        r_sv    [0:SQRT_STEPS];

    always_ff @(posedge i_clk) begin
        r_rem[0]   <= '0;
        r_root[0]  <= '0;
        r_sh[0]    <= n_h;
        r_sflag[0] <= n_flag;
        r_sdx[0]   <= '{neg: w_dx_neg, mag: r_dxm};
        r_sdy[0]   <= r_dy_p;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv[0] <= 1'b0;
        end else begin
            r_sv[0] <= r_pv;
        end
    end

    genvar i;
    generate
        for (i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
            logic [63:0] w_rad;
            logic [34:0] w_rs;
            logic [34:0] w_trial;
            logic        w_ge;

            assign w_rad   = {1'b0, r_sh[i], 31'd0};
            assign w_rs    = {r_rem[i], w_rad[63-2*i -: 2]};
            assign w_trial = {1'b0, r_root[i], 2'b01};
            assign w_ge    = w_rs >= w_trial;

            always_ff @(posedge i_clk) begin
                r_rem[i+1]   <= w_ge ? 33'(w_rs - w_trial) : 33'(w_rs);
                r_root[i+1]  <= {r_root[i][30:0], w_ge};
                r_sh[i+1]    <= r_sh[i];
                r_sflag[i+1] <= r_sflag[i];
                r_sdx[i+1]   <= r_sdx[i];
                r_sdy[i+1]   <= r_sdy[i];
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_sv[i+1] <= 1'b0;
                end else begin
                    r_sv[i+1] <= r_sv[i];
                end
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // Three dividers give round(v * 2^F / s) as floor((2v*2^F + s) / 2s),
    // for v = h, -dy and dx. The remainder of r_rem is no longer needed.
    // ------------------------------------------------------------------
    logic [31:0]      w_root;
    logic [DEN_W-1:0] w_den;
    logic [NUM_W-1:0] w_num_w, w_num_x, w_num_y;
    t_div_side        w_side_w, w_side_x, w_side_y;

    assign w_root  = r_root[SQRT_STEPS];
    assign w_den   = {w_root, 1'b0};
    assign w_num_w = NUM_W'({r_sh[SQRT_STEPS], {QBITS{1'b0}}}) + NUM_W'(w_root);
    assign w_num_x = NUM_W'({1'b0, r_sdy[SQRT_STEPS].mag, {QBITS{1'b0}}}) + NUM_W'(w_root);
    assign w_num_y = NUM_W'({1'b0, r_sdx[SQRT_STEPS].mag, {QBITS{1'b0}}}) + NUM_W'(w_root);

    // x is -dy: negative when dy is a nonzero positive value.
    assign w_side_w = '{neg: 1'b0, opposite: r_sflag[SQRT_STEPS]};
    assign w_side_x = '{neg: !r_sdy[SQRT_STEPS].neg && (r_sdy[SQRT_STEPS].mag != 31'd0),
                        opposite: r_sflag[SQRT_STEPS]};
    assign w_side_y = '{neg: r_sdx[SQRT_STEPS].neg, opposite: r_sflag[SQRT_STEPS]};

    logic                    w_vw, w_vx, w_vy;
    logic signed [QBITS-1:0] w_qw, w_qx, w_qy;
    t_div_side               w_ow, w_ox, w_oy;

    saq_div u_div_w (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_sv[SQRT_STEPS]),
        .i_num   (w_num_w),
        .i_den   (w_den),
        .i_side  (w_side_w),
        .o_valid (w_vw),
        .o_quot  (w_qw),
        .o_side  (w_ow)
    );

    saq_div u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_sv[SQRT_STEPS]),
        .i_num   (w_num_x),
        .i_den   (w_den),
        .i_side  (w_side_x),
        .o_valid (w_vx),
        .o_quot  (w_qx),
        .o_side  (w_ox)
    );

    saq_div u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_sv[SQRT_STEPS]),
        .i_num   (w_num_y),
        .i_den   (w_den),
        .i_side  (w_side_y),
        .o_valid (w_vy),
        .o_quot  (w_qy),
        .o_side  (w_oy)
    );

    // ------------------------------------------------------------------
    // Result register. A direction almost opposite +z has no defined
    // shortest arc, so the half turn about x replaces the quotients.
    // ------------------------------------------------------------------
    logic                    w_opp;
    logic                    r_strobe;
    logic [FRAC_BITS-1:0]    r_quat_w;
    logic signed [QBITS-1:0] r_quat_x;
    logic signed [QBITS-1:0] r_quat_y;
    logic                    r_opp;

    assign w_opp = w_ow.opposite && w_ox.opposite && w_oy.opposite;

    always_ff @(posedge i_clk) begin
        r_opp <= w_opp;
        if (w_opp) begin
            r_quat_w <= '0;
            r_quat_x <= {1'b0, {FRAC_BITS{1'b1}}};
            r_quat_y <= '0;
        end else begin
            r_quat_w <= w_qw[FRAC_BITS-1:0];
            r_quat_x <= w_qx;
            r_quat_y <= w_qy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_vw && w_vx && w_vy;
        end
    end

    assign o_strobe        = r_strobe;
    assign o_quat_w        = r_quat_w;
    assign o_quat_x        = r_quat_x;
    assign o_quat_y        = r_quat_y;
    assign o_opposite_flag = r_opp;

    // The half-turn result carries exactly one nonzero component.
    `SAQ_ASSERT(a_opposite_shape, o_strobe && o_opposite_flag |-> o_quat_w == '0 && o_quat_y == '0 && o_quat_x == {1'b0, {FRAC_BITS{1'b1}}}, "half-turn result malformed")
    // Outside the opposite case h is large enough that w cannot round to zero.
    `SAQ_ASSERT(a_w_nonzero, o_strobe && !o_opposite_flag |-> o_quat_w != '0, "scalar part zero without opposite flag")
    // Reset flushes the valid bits, so no result follows a reset cycle.
    `SAQ_ASSERT_ALWAYS(a_reset_quiet, !i_rst_n |=> !o_strobe, "result strobe after reset")
    // The three dividers run in lockstep.
    `SAQ_ASSERT(a_div_lockstep, w_vw == w_vx && w_vx == w_vy, "divider valid bits disagree")

endmodule

`default_nettype wire

@@ tb/sv/spherical_angles_to_quaternion_unit_test.sv @@
`timescale 1ns / 1ps

module spherical_angles_to_quaternion_unit_test;

    import saq_pkg::*;

    // Stored value of one request, and what the unit must return.
    typedef struct {
        logic [ANGLE_BITS-1:0] phi;
        logic [ANGLE_BITS-1:0] theta;
    } t_request;

    typedef struct {
        logic [FRAC_BITS-1:0]      w;
        logic signed [FRAC_BITS:0] x;
        logic signed [FRAC_BITS:0] y;
        logic                      opposite;
    } t_quat;

    localparam int LATENCY = 70;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_start;
    logic                          o_busy;
    logic [ANGLE_BITS-1:0]         i_phi_angle;
    logic [ANGLE_BITS-1:0]         i_theta_angle;
    logic                          o_strobe;
    logic [FRAC_BITS-1:0]          o_quat_w;
    logic signed [FRAC_BITS:0]     o_quat_x;
    logic signed [FRAC_BITS:0]     o_quat_y;
    logic                          o_opposite_flag;

    spherical_angles_to_quaternion_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_phi_angle     (i_phi_angle),
        .i_theta_angle   (i_theta_angle),
        .o_strobe        (o_strobe),
        .o_quat_w        (o_quat_w),
        .o_quat_x        (o_quat_x),
        .o_quat_y        (o_quat_y),
        .o_opposite_flag (o_opposite_flag)
    );

    // Requests waiting to be driven, and quaternions waiting for the unit to return them.
    t_request pending_requests[$];
    t_quat    expected_quats[$];
    int       mismatch_count = 0;
    int       result_count   = 0;
    int       flagged_count  = 0;
    bit       stimulus_done  = 0;
    // When set, the driver holds off until every expected quaternion has come back.
    bit       drain_hold     = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor. Signed values are kept as 64-bit integers in Q30, with
    // products truncated on magnitudes and the sign applied afterwards.
    // ------------------------------------------------------------------

    // Sine of a 32-bit turn angle: fold to the first quadrant, then a
    // truncating Horner evaluation of the Taylor series up to the ninth power.
    function automatic longint sine_of_turn(logic [31:0] turn);
        logic [1:0]        quadrant;
        logic [63:0]       r, z, z2, t, s;
        quadrant = turn[31:30];
        r = {34'd0, turn[29:0]};
        if (quadrant[0]) begin
            r = {33'd0, ONE_Q30} - r;
        end
        z  = (r * {33'd0, HALF_PI_Q30}) >> 30;
        z2 = (z * z) >> 30;
        t  = {33'd0, ONE_Q30} - z2 / 72;
        t  = {33'd0, ONE_Q30} - ((z2 * t) >> 30) / 42;
        t  = {33'd0, ONE_Q30} - ((z2 * t) >> 30) / 20;
        t  = {33'd0, ONE_Q30} - ((z2 * t) >> 30) / 6;
        s  = (z * t) >> 30;
        if (s > {33'd0, ONE_Q30}) begin
            s = {33'd0, ONE_Q30};
        end
        return quadrant[1] ? -longint'(s) : longint'(s);
    endfunction

    function automatic longint product_q30(longint a, longint b);
        longint unsigned magnitude;
        magnitude = (longint'(a < 0 ? -a : a) * longint'(b < 0 ? -b : b)) >> 30;
        return ((a < 0) != (b < 0)) ? -longint'(magnitude) : longint'(magnitude);
    endfunction

    // Integer square root, bit by bit, floor of the true root.
    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned root, bit_pos;
        root = 0;
        bit_pos = 64'd1 << 62;
        while (bit_pos > v) begin
            bit_pos = bit_pos >> 2;
        end
        while (bit_pos != 0) begin
            if (v >= root + bit_pos) begin
                v = v - (root + bit_pos);
                root = (root >> 1) + bit_pos;
            end else begin
                root = root >> 1;
            end
            bit_pos = bit_pos >> 2;
        end
        return root;
    endfunction

    // Rounded quotient v * 2^F / den with halves away from zero, then saturated.
    function automatic longint rounded_ratio(longint v, longint unsigned den,
                                             longint lo, longint hi);
        longint unsigned numer, quotient;
        longint          value;
        numer    = longint'(v < 0 ? -v : v) << FRAC_BITS;
        quotient = (numer * 2 + den) / (den * 2);
        value    = v < 0 ? -longint'(quotient) : longint'(quotient);
        return value < lo ? lo : (value > hi ? hi : value);
    endfunction

    function automatic t_quat arc_quaternion(t_request req);
        logic [31:0]     phi_turn, theta_turn;
        longint          sin_phi, cos_phi, sin_theta, cos_theta;
        longint          dir_x, dir_y, dir_z, one_f;
        longint unsigned half_sum, root;
        t_quat           q;
        one_f      = longint'(1) << FRAC_BITS;
        phi_turn   = {req.phi, {(32 - ANGLE_BITS){1'b0}}};
        theta_turn = {req.theta, {(32 - ANGLE_BITS){1'b0}}};
        sin_phi    = sine_of_turn(phi_turn);
        cos_phi    = sine_of_turn(phi_turn + QUARTER_TURN);
        sin_theta  = sine_of_turn(theta_turn);
        cos_theta  = sine_of_turn(theta_turn + QUARTER_TURN);
        dir_x      = product_q30(sin_phi, sin_theta);
        dir_y      = cos_phi;
        dir_z      = product_q30(sin_phi, cos_theta);
        // Pointing almost straight away from +z: the arc is undefined, so the
        // unit falls back to a fixed half-turn about x.
        if (dir_z <= -longint'(OPP_LIMIT)) begin
            q.w        = '0;
            q.x        = (FRAC_BITS + 1)'(one_f - 1);
            q.y        = '0;
            q.opposite = 1'b1;
        end else begin
            half_sum   = longint'(ONE_Q30) + dir_z;
            root       = floor_root((2 * half_sum) << 30);
            q.w        = FRAC_BITS'(rounded_ratio(half_sum, root, 0, one_f - 1));
            q.x        = (FRAC_BITS + 1)'(rounded_ratio(-dir_y, root, -one_f, one_f - 1));
            q.y        = (FRAC_BITS + 1)'(rounded_ratio(dir_x, root, -one_f, one_f - 1));
            q.opposite = 1'b0;
        end
        return q;
    endfunction

    // ------------------------------------------------------------------
    // Driver: inputs change on the falling edge. A request presented at a
    // falling edge is taken at the next rising edge if busy is low there, so
    // the driver looks at what happened at that rising edge before moving on.
    // ------------------------------------------------------------------
    int gap_left = 0;

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            // Retire the request that the last rising edge accepted.
            if (i_start && !o_busy) begin
                expected_quats.push_back(arc_quaternion(pending_requests.pop_front()));
                gap_left = pick_gap();
            end
            if (gap_left > 0) begin
                gap_left--;
                i_start <= 1'b0;
            end else if (drain_hold || pending_requests.size() == 0) begin
                i_start <= 1'b0;
            end else begin
                i_start       <= 1'b1;
                i_phi_angle   <= pending_requests[0].phi;
                i_theta_angle <= pending_requests[0].theta;
            end
        end
    end

    task automatic report_mismatch(string what, longint got, longint want);
        mismatch_count++;
        $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    // Monitor: every strobe is one returned quaternion, compared with the oldest expectation.
    always @(posedge i_clk) begin
        t_quat want;
        if (i_rst_n && o_strobe) begin
            result_count++;
            if (expected_quats.size() == 0) begin
                mismatch_count++;
                $display("MISMATCH at %0t: result with no request outstanding", $realtime);
            end else begin
                want = expected_quats.pop_front();
                if (want.opposite) flagged_count++;
                if (o_quat_w !== want.w) report_mismatch("quat_w", o_quat_w, want.w);
                if (o_quat_x !== want.x) report_mismatch("quat_x", o_quat_x, want.x);
                if (o_quat_y !== want.y) report_mismatch("quat_y", o_quat_y, want.y);
                if (o_opposite_flag !== want.opposite) begin
                    report_mismatch("opposite_flag", o_opposite_flag, want.opposite);
                end
            end
        end
    end

    task automatic add_request(logic [ANGLE_BITS-1:0] phi, logic [ANGLE_BITS-1:0] theta);
        t_request req;
        req.phi   = phi;
        req.theta = theta;
        pending_requests.push_back(req);
    endtask

    // A random angle: mostly uniform, sometimes snapped near a quadrant edge
    // so that the axes and the near-opposite cone are visited often.
    function automatic logic [ANGLE_BITS-1:0] random_angle();
        logic [ANGLE_BITS-1:0] base;
        if ($urandom_range(0, 3) != 0) return ANGLE_BITS'($urandom);
        base = ANGLE_BITS'($urandom_range(0, 3)) << (ANGLE_BITS - 2);
        return base + ANGLE_BITS'($urandom_range(0, 8)) - ANGLE_BITS'(4);
    endfunction

    initial begin
        i_rst_n       = 1'b0;
        i_start       = 1'b0;
        i_phi_angle   = '0;
        i_theta_angle = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: axes and extremes. phi = quarter turn with theta = 0 points
        // along +z, where w saturates; theta = half turn points along -z, the
        // near-opposite case. Neighbors of -z probe the edge of that cone.
        add_request(16'h0000, 16'h0000);
        add_request(16'hFFFF, 16'hFFFF);
        add_request(16'h4000, 16'h0000);
        add_request(16'h4000, 16'h8000);
        add_request(16'hC000, 16'h0000);
        add_request(16'hC000, 16'h8000);
        add_request(16'h4000, 16'h7FFF);
        add_request(16'h4000, 16'h8001);
        add_request(16'h3FFF, 16'h8000);
        add_request(16'h4001, 16'h8000);
        add_request(16'h4000, 16'h7FF0);
        add_request(16'h8000, 16'h4000);
        add_request(16'h4000, 16'h4000);
        add_request(16'h4000, 16'hC000);
        add_request(16'h2000, 16'h6000);
        add_request(16'hAAAA, 16'h5555);
        add_request(16'h5555, 16'hAAAA);
        add_request(16'h8000, 16'h8000);
        add_request(16'h0001, 16'h0001);

        for (int i = 0; i < 1250; i++) begin
            add_request(random_angle(), random_angle());
            // Let the pipeline run dry twice along the way.
            if (i == 400 || i == 900) begin
                wait (pending_requests.size() == 0);
                drain_hold = 1'b1;
                wait (expected_quats.size() == 0);
                @(negedge i_clk);
                drain_hold = 1'b0;
            end
        end
        stimulus_done = 1'b1;
    end

    initial begin
        wait (stimulus_done && pending_requests.size() == 0);
        // The last request may still be held by the driver.
        @(negedge i_clk);
        @(negedge i_clk);
        wait (expected_quats.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("Returned %0d quaternions, %0d of them on the half-turn fallback.",
                 result_count, flagged_count);
        $display("Angles covered both axes, all quadrants and the edge of the -z cone.");
        if (mismatch_count == 0 && expected_quats.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Timed out with %0d requests outstanding.", expected_quats.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule
